### hw/rtl/asma_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asma_pkg
// Shared constants and types for the scan moving-average block.
// ----------------------------------------------------------------------------
package asma_pkg;

  localparam int unsigned NumChannels = 4;

  // default window depths and discard run
  localparam int unsigned DefLeftDepth    = 8;
  localparam int unsigned DefMiddleDepth  = 8;
  localparam int unsigned DefRightDepth   = 8;
  localparam int unsigned DefBatteryDepth = 8;
  localparam int unsigned DefDiscardCount = 3;

  localparam int unsigned SampleWidth = 10;
  localparam int unsigned SumWidth    = 16;
  localparam int unsigned MuxWidth    = 4;
  localparam int unsigned VoltsWidth  = 8;

  // sum / depth as (sum * recip) >> RecipShift, exact for 16-bit sums, depth <= 64
  localparam int unsigned RecipShift = 22;
  localparam int unsigned RecipWidth = RecipShift + 1;
  localparam int unsigned ProdWidth  = SumWidth + RecipWidth;

  // avg / 5 as (avg * 1639) >> 13, exact for 10-bit averages
  localparam int unsigned VoltShift = 13;
  localparam int unsigned VoltProdW = SampleWidth + 11;
  localparam logic [10:0] VoltRecip = 11'd1639;
  localparam logic [VoltsWidth-1:0] VoltOffset = 8'd4;

  typedef enum logic [1:0] {
    PosLeft    = 2'd0,
    PosMiddle  = 2'd1,
    PosRight   = 2'd2,
    PosBattery = 2'd3
  } scan_pos_e;

  typedef enum logic [3:0] {
    CfgLeftMux    = 4'd0,
    CfgMidMux     = 4'd1,
    CfgRightMux   = 4'd2,
    CfgBatteryMux = 4'd3
  } cfg_index_e;

  localparam logic [MuxWidth-1:0] LeftMuxReset    = 4'd0;
  localparam logic [MuxWidth-1:0] MidMuxReset     = 4'd1;
  localparam logic [MuxWidth-1:0] RightMuxReset   = 4'd2;
  localparam logic [MuxWidth-1:0] BatteryMuxReset = 4'd3;

endpackage

### hw/rtl/adc_scan_moving_average_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_scan_moving_average_top
// Round-robin converter scan with a moving-average window per channel.
// ----------------------------------------------------------------------------
// path: an accepted input beat is registered in stage 1, stage 2, stage 3 and the output register in turn
// throughput: one beat per cycle while the output is not stalled; the ring store read at accept, the sum update
//   and the sum/reciprocal multiply each sit in a stage of their own
// reset: scan position, discard count, sums and mux codes return to defaults;
//   ring entries read as zero until written (per-entry valid bits, no clearing pass)
module adc_scan_moving_average_top #(
  parameter int unsigned LeftDepth    = asma_pkg::DefLeftDepth,
  parameter int unsigned MiddleDepth  = asma_pkg::DefMiddleDepth,
  parameter int unsigned RightDepth   = asma_pkg::DefRightDepth,
  parameter int unsigned BatteryDepth = asma_pkg::DefBatteryDepth,
  parameter int unsigned DiscardCount = asma_pkg::DefDiscardCount
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream: [9:0] sample
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,
  // output stream: [1:0] kept_position, [5:2] next_mux, [15:6] avg_left,
  // [25:16] avg_middle, [35:26] avg_right, [45:36] avg_battery,
  // [53:46] battery_volts
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [55:0] m_axis_tdata_o,
  // output user: [0] kept
  output logic        m_axis_tuser_o,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_index_i,
  input  logic [3:0]  cfg_data_i
);
  import asma_pkg::*;

  localparam logic [1:0] DiscardLim = 2'(DiscardCount);

  // mux code registers
  logic [MuxWidth-1:0] mux_q [NumChannels];

  // scan control
  logic [1:0] scan_q, scan_d;
  logic [1:0] discard_q, discard_d;
  logic       keep_now;
  logic       in_fire;

  // pipeline valids and handshake
  logic v1_q, v2_q, v3_q, vo_q;
  logic load2, load3, loado;
  logic rdy1, rdy2, rdy3;

  // stage 1 payload
  logic                   kept1_q;
  logic [1:0]             pos1_q;
  logic [1:0]             npos1_q;
  logic [SampleWidth-1:0] sample1_q;
  // stage 2 / 3 payload
  logic       kept2_q, kept3_q;
  logic [1:0] pos2_q, pos3_q;
  logic [1:0] npos2_q, npos3_q;

  // per-channel state
  logic [SumWidth-1:0]    sum_q [NumChannels];
  logic [SampleWidth-1:0] avg3_q [NumChannels];

  // output registers
  logic                   kept_o_q;
  logic [1:0]             kpos_o_q;
  logic [MuxWidth-1:0]    nmux_o_q;
  logic [SampleWidth-1:0] avg_o_q [NumChannels];
  logic [VoltsWidth-1:0]  volts_o_q;
  logic [VoltProdW-1:0]   volt_prod;
  logic [VoltsWidth-1:0]  volts_d;

  // ---------------------------------------------------------------------------
  // handshake chain
  // ---------------------------------------------------------------------------
  assign loado = v3_q && (!vo_q || m_axis_tready_i);
  assign rdy3  = !v3_q || loado;
  assign load3 = v2_q && rdy3;
  assign rdy2  = !v2_q || load3;
  assign load2 = v1_q && rdy2;
  assign rdy1  = !v1_q || load2;

  assign s_axis_tready_o = rdy1;
  assign in_fire         = s_axis_tvalid_i && rdy1;
  assign cfg_ready_o     = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      v1_q <= in_fire || (v1_q && !load2);
      v2_q <= load2 || (v2_q && !load3);
      v3_q <= load3 || (v3_q && !loado);
      vo_q <= loado || (vo_q && !m_axis_tready_i);
    end
  end

  // ---------------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mux_q[PosLeft]    <= LeftMuxReset;
      mux_q[PosMiddle]  <= MidMuxReset;
      mux_q[PosRight]   <= RightMuxReset;
      mux_q[PosBattery] <= BatteryMuxReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgLeftMux:    mux_q[PosLeft]    <= cfg_data_i;
        CfgMidMux:     mux_q[PosMiddle]  <= cfg_data_i;
        CfgRightMux:   mux_q[PosRight]   <= cfg_data_i;
        CfgBatteryMux: mux_q[PosBattery] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // discard counter and scan position; the scan position advances only on kept beats
  // ---------------------------------------------------------------------------
  assign keep_now = !(discard_q < DiscardLim);

  always_comb begin
    discard_d = discard_q;
    scan_d    = scan_q;
    if (in_fire) begin
      if (keep_now) begin
        discard_d = 2'd0;
        scan_d    = scan_q + 2'd1;
      end else begin
        discard_d = discard_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      discard_q <= 2'd0;
      scan_q    <= PosLeft;
    end else begin
      discard_q <= discard_d;
      scan_q    <= scan_d;
    end
  end

  // ---------------------------------------------------------------------------
  // pipeline payload
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kept1_q   <= keep_now;
      pos1_q    <= keep_now ? scan_q : PosLeft;
      npos1_q   <= scan_d;
      sample1_q <= s_axis_tdata_i[SampleWidth-1:0];
    end
    if (load2) begin
      kept2_q <= kept1_q;
      pos2_q  <= pos1_q;
      npos2_q <= npos1_q;
    end
    if (load3) begin
      kept3_q <= kept2_q;
      pos3_q  <= pos2_q;
      npos3_q <= npos2_q;
    end
  end

  // ---------------------------------------------------------------------------
  // per-channel ring store, running sum and average
  // ---------------------------------------------------------------------------
  for (genvar c = 0; c < NumChannels; c++) begin : g_chan
    localparam int unsigned Dep = (c == 0) ? LeftDepth :
                                  (c == 1) ? MiddleDepth :
                                  (c == 2) ? RightDepth : BatteryDepth;
    localparam int unsigned SlotW = (Dep > 1) ? $clog2(Dep) : 1;
    localparam logic [SlotW-1:0] LastSlot = SlotW'(Dep - 1);
    localparam logic [RecipWidth-1:0] Recip =
      RecipWidth'(((64'd1 << RecipShift) + 64'(Dep) - 64'd1) / 64'(Dep));

    logic [SampleWidth-1:0] store_q [Dep];
    logic [Dep-1:0]         filled_q;
    logic [SlotW-1:0]       slot_q;
    logic [SlotW-1:0]       wslot_q;
    logic [SampleWidth-1:0] old_q;
    logic                   old_ok_q;
    logic [SampleWidth-1:0] old_val;
    logic                   rd_en;
    logic                   wr_en;
    logic [ProdWidth-1:0]   prod;

    assign rd_en   = in_fire && keep_now && (scan_q == 2'(c));
    assign wr_en   = load2 && kept1_q && (pos1_q == 2'(c));
    assign old_val = old_ok_q ? old_q : '0;
    assign prod    = ProdWidth'(sum_q[c]) * ProdWidth'(Recip);

    // store read at accept, written back one stage later
    always_ff @(posedge clk_i) begin
      if (rd_en) begin
        old_q   <= store_q[slot_q];
        wslot_q <= slot_q;
      end
      if (wr_en) begin
        store_q[wslot_q] <= sample1_q;
      end
      if (load3) begin
        avg3_q[c] <= prod[RecipShift +: SampleWidth];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        filled_q <= '0;
        slot_q   <= '0;
        old_ok_q <= 1'b0;
        sum_q[c] <= '0;
      end else begin
        if (rd_en) begin
          old_ok_q <= filled_q[slot_q];
          slot_q   <= (slot_q == LastSlot) ? '0 : slot_q + SlotW'(1);
        end
        if (wr_en) begin
          filled_q[wslot_q] <= 1'b1;
          sum_q[c] <= sum_q[c] - SumWidth'(old_val) + SumWidth'(sample1_q);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  assign volt_prod = VoltProdW'(avg3_q[PosBattery]) * VoltProdW'(VoltRecip);
  assign volts_d   = volt_prod[VoltShift +: VoltsWidth] + VoltOffset;

  always_ff @(posedge clk_i) begin
    if (loado) begin
      kept_o_q  <= kept3_q;
      kpos_o_q  <= pos3_q;
      nmux_o_q  <= mux_q[npos3_q];
      avg_o_q   <= avg3_q;
      volts_o_q <= volts_d;
    end
  end

  assign m_axis_tvalid_o = vo_q;
  assign m_axis_tuser_o  = kept_o_q;
  assign m_axis_tdata_o  = {2'b00, volts_o_q, avg_o_q[PosBattery], avg_o_q[PosRight],
                            avg_o_q[PosMiddle], avg_o_q[PosLeft], nmux_o_q, kpos_o_q};

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_discard_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    discard_q <= DiscardLim)
    else $error("discard counter beyond its limit");

  a_scan_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && keep_now) |=> (scan_q == $past(scan_q) + 2'd1))
    else $error("scan position did not advance on a kept beat");

  a_scan_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !keep_now) |=> (scan_q == $past(scan_q)))
    else $error("scan position moved on a discarded beat");

  a_discard_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |-> (m_axis_tdata_o[1:0] == PosLeft))
    else $error("discarded beat carries a nonzero position");

  a_sum_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sum_q[PosLeft] <= SumWidth'(LeftDepth * 1023)) &&
    (sum_q[PosBattery] <= SumWidth'(BatteryDepth * 1023)))
    else $error("window sum exceeds its window capacity");

endmodule
